// ----- rtl/obst_pkg.sv -----
// Shared constants and types for the optimal binary search tree cost table.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package obst_pkg;
  localparam int MaxKeys   = 16;
  localparam int IdxW      = 6;
  localparam int KeyW      = $clog2(MaxKeys);
  localparam int CntW      = 7;
  localparam int WeightW   = 16;
  localparam int CostW     = 28;
  localparam int AddrW     = 2 * KeyW;
  localparam int TableD    = MaxKeys * MaxKeys;
  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic           wt_wr;     // store weight at i
    logic           diag_wr;   // write diagonal entry (i,i)
    logic           lrd_rd;    // issue reads for (i,k-1) and (k+1,j)
    logic           eval;      // fold the read data for root k
    logic           first;     // k == i
    logic           has_l;     // k > i
    logic           has_r;     // k < j
    logic           cell_wr;   // write (i,j) from best
    logic           q_rd;      // issue read of (i,j) for a result
    logic [KeyW-1:0] i;
    logic [KeyW-1:0] j;
    logic [KeyW-1:0] k;
  } dp_cmd_t;
endpackage
`default_nettype wire

// ----- rtl/obst_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module obst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

// ----- rtl/obst_datapath.sv -----
// Datapath: weight store, cost/root table memories, running minimum and sum.
// Depends on obst_pkg and obst_ram.
`timescale 1ns / 1ps
`default_nettype none
module obst_datapath (
  input  wire logic                         clk_i,
  input  wire obst_pkg::dp_cmd_t            cmd_i,
  input  wire logic [obst_pkg::WeightW-1:0] weight_i,
  output logic      [obst_pkg::CostW-1:0]   cost_o,
  output logic      [obst_pkg::IdxW-1:0]    root_o
);
  import obst_pkg::*;

  logic [WeightW-1:0] wt_q [MaxKeys];
  logic [CostW+1:0]   best_q, best_d, sum_q, sum_d, cand;
  logic [KeyW-1:0]    bk_q, bk_d;
  logic [KeyW-1:0]    kd_q;
  logic               has_l_q, has_r_q, first_q, eval_q;
  logic [AddrW-1:0]   ra, rb, wa;
  logic [CostW-1:0]   ca, cb, wc, lc, rc;
  logic [KeyW-1:0]    ro_a, ro_b, wr;
  logic [CostW+1:0]   tot;
  logic               we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_wr) begin
      wt_q[cmd_i.i] <= weight_i;
    end
    // Read data comes back registered from the RAM; eval and the k metadata are registered to match.
    eval_q  <= cmd_i.eval;
    has_l_q <= cmd_i.has_l;
    has_r_q <= cmd_i.has_r;
    first_q <= cmd_i.first;
    kd_q    <= cmd_i.k;
    best_q  <= best_d;
    sum_q   <= sum_d;
    bk_q    <= bk_d;
  end

  assign ra = cmd_i.q_rd ? {cmd_i.i, cmd_i.j} : {cmd_i.i, cmd_i.k - KeyW'(1)};
  assign rb = {cmd_i.k + KeyW'(1), cmd_i.j};

  assign lc   = has_l_q ? ca : '0;
  assign rc   = has_r_q ? cb : '0;
  assign cand = {2'b00, lc} + {2'b00, rc};

  always_comb begin
    best_d = best_q;
    bk_d   = bk_q;
    sum_d  = sum_q;
    if (eval_q) begin
      if (first_q || cand < best_q) begin
        best_d = cand;
        bk_d   = kd_q;
      end
      sum_d = (first_q ? '0 : sum_q) + (CostW+2)'(wt_q[kd_q]);
    end
  end

  assign tot = best_q + sum_q;
  assign we  = cmd_i.diag_wr | cmd_i.cell_wr;
  assign wa  = {cmd_i.i, cmd_i.j};
  assign wc  = cmd_i.diag_wr ? CostW'(wt_q[cmd_i.i])
             : ((tot > (CostW+2)'(CostMax)) ? CostMax : tot[CostW-1:0]);
  assign wr  = cmd_i.diag_wr ? cmd_i.i : bk_q;

  obst_ram #(.Width(CostW), .Depth(TableD)) u_cost (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wc),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(ca), .rdata_b_o(cb)
  );
  obst_ram #(.Width(KeyW), .Depth(TableD)) u_root (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wr),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(ro_a), .rdata_b_o(ro_b)
  );

  // ro_b is only needed for symmetry of the RAM; it carries no result.
  assign cost_o = ca;
  assign root_o = IdxW'(ro_a) | IdxW'(ro_b & '0);
endmodule
`default_nettype wire

// ----- rtl/obst_ctrl.sv -----
// Controller: load sequencing, interval sweep of the table fill, query issue.
// Depends on obst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obst_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic                       kind_i,
  input  wire logic                       last_i,
  input  wire logic [obst_pkg::IdxW-1:0]  left_index_i,
  input  wire logic [obst_pkg::IdxW-1:0]  right_index_i,
  output logic                            busy_o,
  output obst_pkg::dp_cmd_t               cmd_o,
  output logic                            res_rd_o,
  output logic                            res_err_o,
  output logic                            done_o,
  output logic                            done_err_o
);
  import obst_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StDiag, StIssue, StLast, StWrite, StRes
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            ready_q;
  logic [KeyW-1:0] i_q, j_q, k_q, d_q;
  logic            accept, full, qbad;
  logic [KeyW-1:0] nkm1;

  assign accept = start_i && !busy_o;
  assign full   = cnt_q >= CntW'(MaxKeys);
  assign nkm1   = KeyW'(cnt_q - CntW'(1));
  assign qbad   = !ready_q || (left_index_i > right_index_i)
                || ({1'b0, right_index_i} >= cnt_q);
  assign busy_o = (state_q != StIdle);

  always_comb begin
    cmd_o       = '0;
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.k     = k_q;
    cmd_o.first = (k_q == i_q);
    cmd_o.has_l = (k_q != i_q);
    cmd_o.has_r = (k_q != j_q);
    res_rd_o    = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept && kind_i == KindLoad) begin
          cmd_o.i = (ready_q || full) ? '0 : KeyW'(cnt_q);
          cmd_o.wt_wr = !full || ready_q;
        end else if (accept) begin
          cmd_o.i    = KeyW'(left_index_i);
          cmd_o.j    = KeyW'(right_index_i);
          cmd_o.q_rd = 1'b1;
          res_rd_o   = !qbad;
        end
      end
      StDiag:  cmd_o.diag_wr = 1'b1;
      StIssue: begin
        cmd_o.lrd_rd = 1'b1;
        cmd_o.eval   = 1'b1;
      end
      StWrite: cmd_o.cell_wr = 1'b1;
      StRes: begin
        cmd_o.i    = '0;
        cmd_o.j    = nkm1;
        cmd_o.q_rd = 1'b1;
        res_rd_o   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      ready_q    <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      d_q        <= '0;
      res_err_o  <= 1'b0;
      done_o     <= 1'b0;
      done_err_o <= 1'b0;
    end else begin
      res_err_o  <= 1'b0;
      done_o     <= 1'b0;
      done_err_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept && kind_i == KindLoad) begin
            if (ready_q) begin
              ready_q <= 1'b0;
              cnt_q   <= CntW'(1);
            end else if (!full) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            if (last_i) begin
              i_q     <= '0;
              j_q     <= '0;
              state_q <= StDiag;
            end
          end else if (accept) begin
            // Query: data comes from RAM next cycle; the status flags are registered and arrive with it.
            if (qbad) begin
              done_o     <= 1'b1;
              done_err_o <= 1'b1;
            end else begin
              res_err_o <= 1'b1;
            end
          end
        end
        StDiag: begin
          if (i_q == nkm1) begin
            if (cnt_q == CntW'(1)) begin
              state_q <= StRes;
            end else begin
              d_q <= KeyW'(1);
              i_q <= '0;
              j_q <= KeyW'(1);
              k_q <= '0;
              state_q <= StIssue;
            end
          end else begin
            i_q <= i_q + KeyW'(1);
            j_q <= j_q + KeyW'(1);
          end
        end
        StIssue: begin
          if (k_q == j_q) begin
            state_q <= StLast;
          end else begin
            k_q <= k_q + KeyW'(1);
          end
        end
        StLast:  state_q <= StWrite;
        StWrite: begin
          if (j_q == nkm1) begin
            if (d_q == nkm1) begin
              state_q <= StRes;
            end else begin
              d_q <= d_q + KeyW'(1);
              i_q <= '0;
              j_q <= d_q + KeyW'(1);
              k_q <= '0;
              state_q <= StIssue;
            end
          end else begin
            i_q <= i_q + KeyW'(1);
            j_q <= j_q + KeyW'(1);
            k_q <= i_q + KeyW'(1);
            state_q <= StIssue;
          end
        end
        StRes: begin
          ready_q   <= 1'b1;
          res_err_o <= 1'b1;
          state_q   <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/optimal_bst_cost_table_unit.sv -----
// Channel  | Signals                                         | Handshake
// command  | kind_i weight_i last_i left_index_i right_index_i | start_i & !busy_o
// result   | cost_o root_o error_o                           | valid_o, one cycle
//
// A query result comes from the registered RAM read. A load without last gives no
// result. A final load runs the table fill: a diagonal write per key, then per
// interval a read step per root, a last step and a write step, and a result step.
// Reset clears key count and the ready flag; tables need no clearing pass.
// The receiver cannot stall; a result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module optimal_bst_cost_table_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic                          kind_i,
  input  wire logic [obst_pkg::WeightW-1:0]  weight_i,
  input  wire logic                          last_i,
  input  wire logic [obst_pkg::IdxW-1:0]     left_index_i,
  input  wire logic [obst_pkg::IdxW-1:0]     right_index_i,
  output logic                               valid_o,
  output logic [obst_pkg::CostW-1:0]         cost_o,
  output logic [obst_pkg::IdxW-1:0]          root_o,
  output logic                               error_o
);
  import obst_pkg::*;

  dp_cmd_t          cmd;
  logic             res_rd, rd_ok, done, done_err;
  logic [CostW-1:0] dp_cost;
  logic [IdxW-1:0]  dp_root;

  obst_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .kind_i, .last_i, .left_index_i, .right_index_i,
    .busy_o, .cmd_o(cmd), .res_rd_o(res_rd), .res_err_o(rd_ok),
    .done_o(done), .done_err_o(done_err)
  );

  obst_datapath u_dp (
    .clk_i, .cmd_i(cmd), .weight_i, .cost_o(dp_cost), .root_o(dp_root)
  );

  // rd_ok marks the cycle after a good read was issued; done marks a bad query.
  assign valid_o = rd_ok | done;
  assign error_o = done & done_err;
  assign cost_o  = rd_ok ? dp_cost : '0;
  assign root_o  = rd_ok ? dp_root : '0;

  logic unused_rd;
  assign unused_rd = res_rd;
endmodule
`default_nettype wire

// ----- rtl/obst_checker.sv -----
// Port-level checker for the cost table unit, bound to the top level.
// Depends on obst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obst_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic                         kind_i,
  input wire logic                         last_i,
  input wire logic                         valid_o,
  input wire logic                         error_o,
  input wire logic [obst_pkg::CostW-1:0]   cost_o,
  input wire logic [obst_pkg::IdxW-1:0]    root_o
);
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_o |-> cost_o == '0 && root_o == '0) else $error("err payload");
  a_query_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && kind_i |=> valid_o) else $error("query");
  a_load_nores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !kind_i && !last_i |=> !valid_o) else $error("load");
  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !kind_i && last_i |=> busy_o) else $error("fill");
  a_no_err_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !error_o) else $error("stray err");
endmodule

bind optimal_bst_cost_table_unit obst_checker u_obst_checker (.*);
`default_nettype wire

// ----- bench/tb_optimal_bst_cost_table_unit.sv -----
// Self-checking bench for optimal_bst_cost_table_unit: weight loads, table fills and queries.
// Expected results come from a behavioral cost/root table builder; depends on rtl/obst_pkg.sv.
`timescale 1ns / 1ps
module tb_optimal_bst_cost_table_unit;
  import obst_pkg::*;

  typedef struct packed {
    logic                 kind;
    logic [WeightW-1:0]   weight;
    logic                 last;
    logic [IdxW-1:0]      left_idx;
    logic [IdxW-1:0]      right_idx;
  } obst_cmd_t;

  typedef struct packed {
    logic [CostW-1:0] cost;
    logic [IdxW-1:0]  root;
    logic             err;
  } obst_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic kind_i = 1'b0;
  logic [WeightW-1:0] weight_i = '0;
  logic last_i = 1'b0;
  logic [IdxW-1:0] left_index_i = '0;
  logic [IdxW-1:0] right_index_i = '0;
  logic busy_o, valid_o, error_o;
  logic [CostW-1:0] cost_o;
  logic [IdxW-1:0] root_o;

  optimal_bst_cost_table_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral copy of the block state.
  logic [WeightW-1:0] key_weight [MaxKeys];
  int unsigned        keys_held;
  logic [CostW-1:0]   cost_tab [MaxKeys][MaxKeys];
  logic [IdxW-1:0]    root_tab [MaxKeys][MaxKeys];
  logic               tab_ready;

  obst_cmd_t pending_cmds[$];
  obst_res_t expected_results[$];
  int unsigned send_idle_pct = 0;
  bit hold_sender = 1'b0;
  int unsigned fail_count = 0;
  int unsigned checked_count = 0;
  int unsigned fills_done = 0;
  int unsigned errors_seen = 0;
  longint unsigned cycle_count = 0;

  task automatic build_tables();
    longint unsigned best, total, lc, rc, v;
    int unsigned best_k, j;
    for (int i = 0; i < keys_held; i++) begin
      cost_tab[i][i] = CostW'(key_weight[i]);
      root_tab[i][i] = IdxW'(i);
    end
    for (int d = 1; d < keys_held; d++) begin
      for (int i = 0; i + d < keys_held; i++) begin
        j = i + d;
        best = 0;
        best_k = i;
        total = 0;
        for (int k = i; k <= j; k++) begin
          lc = (k > i) ? cost_tab[i][k-1] : 0;
          rc = (k < j) ? cost_tab[k+1][j] : 0;
          v = lc + rc;
          if (k == i || v < best) begin
            best = v;
            best_k = k;
          end
          total += key_weight[k];
        end
        cost_tab[i][j] = (best + total > CostMax) ? CostMax : CostW'(best + total);
        root_tab[i][j] = IdxW'(best_k);
      end
    end
    tab_ready = 1'b1;
    fills_done++;
  endtask

  task automatic predict_cmd(input obst_cmd_t c);
    obst_res_t r;
    if (c.kind == KindLoad) begin
      if (tab_ready) begin
        tab_ready = 1'b0;
        keys_held = 0;
      end
      if (keys_held < MaxKeys) begin
        key_weight[keys_held] = c.weight;
        keys_held++;
      end
      if (c.last) begin
        build_tables();
        r.cost = cost_tab[0][keys_held-1];
        r.root = root_tab[0][keys_held-1];
        r.err = 1'b0;
        expected_results.push_back(r);
      end
    end else begin
      if (!tab_ready || c.left_idx > c.right_idx || c.right_idx >= keys_held) begin
        r = '{cost: '0, root: '0, err: 1'b1};
      end else begin
        r.cost = cost_tab[c.left_idx][c.right_idx];
        r.root = root_tab[c.left_idx][c.right_idx];
        r.err = 1'b0;
      end
      expected_results.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    $display("ERROR cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Driver: a transfer happens at the edge where start_i is high and busy_o low.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (!start_i || !busy_o) begin
        if (start_i) predict_cmd({kind_i, weight_i, last_i, left_index_i, right_index_i});
        if (pending_cmds.size() > 0 && !hold_sender &&
            $urandom_range(99, 0) >= send_idle_pct) begin
          {kind_i, weight_i, last_i, left_index_i, right_index_i} <= pending_cmds.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    obst_res_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result cost", cost_o, 0);
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (error_o) errors_seen++;
        if (error_o !== want.err) report_mismatch("error", error_o, want.err);
        if (cost_o !== want.cost) report_mismatch("cost", cost_o, want.cost);
        if (root_o !== want.root) report_mismatch("root", root_o, want.root);
      end
    end
  end

  function automatic obst_cmd_t load_cmd(input logic [WeightW-1:0] w, input logic lst);
    obst_cmd_t c;
    c.kind = KindLoad;
    c.weight = w;
    c.last = lst;
    c.left_idx = IdxW'($urandom);
    c.right_idx = IdxW'($urandom);
    return c;
  endfunction

  function automatic obst_cmd_t query_cmd(input int unsigned l, input int unsigned r);
    obst_cmd_t c;
    c.kind = KindQuery;
    c.weight = WeightW'($urandom);
    c.last = 1'($urandom);
    c.left_idx = IdxW'(l);
    c.right_idx = IdxW'(r);
    return c;
  endfunction

  // One key set of n weights (n may exceed MaxKeys) followed by some queries.
  task automatic queue_key_set(input int unsigned n, input int unsigned nq);
    int unsigned l, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3, 0))
        0: pending_cmds.push_back(load_cmd('1, i == n - 1));
        1: pending_cmds.push_back(load_cmd(WeightW'($urandom_range(15, 0)), i == n - 1));
        default: pending_cmds.push_back(load_cmd(WeightW'($urandom), i == n - 1));
      endcase
    end
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(9, 0) < 8) begin
        r = $urandom_range((n > MaxKeys ? MaxKeys : n) - 1, 0);
        l = $urandom_range(r, 0);
      end else begin
        l = $urandom_range(63, 0);
        r = $urandom_range(63, 0);
      end
      pending_cmds.push_back(query_cmd(l, r));
    end
  endtask

  task automatic drain_all();
    while (pending_cmds.size() > 0 || start_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    tab_ready = 1'b0;
    keys_held = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: queries with no table, extremes, overflow, bad intervals.
    pending_cmds.push_back(query_cmd(0, 0));
    pending_cmds.push_back(query_cmd(63, 63));
    pending_cmds.push_back(load_cmd('0, 1'b1));
    pending_cmds.push_back(query_cmd(0, 0));
    pending_cmds.push_back(query_cmd(0, 1));
    for (int i = 0; i < MaxKeys + 2; i++)
      pending_cmds.push_back(load_cmd('1, i == MaxKeys + 1));
    pending_cmds.push_back(query_cmd(0, MaxKeys - 1));
    pending_cmds.push_back(query_cmd(5, 2));
    pending_cmds.push_back(query_cmd(0, MaxKeys));
    drain_all();

    // Queue a key set, pause the sender, then release it and drain.
    queue_key_set(4, 3);
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    drain_all();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 61 : 0;
      for (int s = 0; s < 45; s++) begin
        if ($urandom_range(9, 0) == 0) queue_key_set($urandom_range(MaxKeys + 3, 13), 8);
        else queue_key_set($urandom_range(6, 1), 8);
        if (s % 15 == 14) drain_all();
      end
      drain_all();
    end
    repeat (50) @(posedge clk_i);

    $display("Checked %0d results over %0d table fills; %0d were error replies.",
             checked_count, fills_done, errors_seen);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("optimal_bst_cost_table_unit: match");
    end else begin
      $display("optimal_bst_cost_table_unit: mismatch");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    wait (cycle_count > 3000000);
    $display("Timeout after %0d cycles.", cycle_count);
    $display("optimal_bst_cost_table_unit: mismatch");
    $finish;
  end
endmodule

// ----- optimal_bst_cost_table_unit.f -----
rtl/obst_pkg.sv
rtl/obst_ram.sv
rtl/obst_datapath.sv
rtl/obst_ctrl.sv
rtl/optimal_bst_cost_table_unit.sv
rtl/obst_checker.sv
bench/tb_optimal_bst_cost_table_unit.sv
